// ===== rtl/core/bdr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_pkg
// Types and constants shared by the button debounce with repeat unit.
// ----------------------------------------------------------------------------
package bdr_pkg;

  localparam int THRESH_W  = 16;
  localparam int COUNT_W   = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_RISE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd2;

  typedef enum logic [3:0] {
    PH_STEADY_LOW  = 4'b0001,
    PH_RISING      = 4'b0010,
    PH_STEADY_HIGH = 4'b0100,
    PH_FALLING     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic sample_level;
    logic ack_change;
    logic ack_repeat;
  } in_t;

  typedef struct packed {
    logic debounced_level;
    logic change_pending;
    logic held_event;
  } out_t;

  typedef struct packed {
    logic [THRESH_W-1:0] rise_threshold;
    logic [THRESH_W-1:0] fall_threshold;
    logic [THRESH_W-1:0] repeat_threshold;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/bdr_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_cfg
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module bdr_cfg
  import bdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [THRESH_W-1:0]  wr_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_RISE: begin
          cfg.rise_threshold <= wr_data;
        end
        REG_FALL: begin
          cfg.fall_threshold <= wr_data;
        end
        REG_REPEAT: begin
          cfg.repeat_threshold <= wr_data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bdr_fsm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdr_fsm
// Debounce phase machine with tick counter and change flag.
// ----------------------------------------------------------------------------
module bdr_fsm
  import bdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic load,
  input  wire in_t  item,
  output out_t      result
);

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] tick_count, count_next, count_inc;
  logic               change_flag, change_flag_next, flag_step;
  logic               high_now;
  logic               rep_on;
  logic [COUNT_W-1:0] rise_lim, fall_lim, rep_lim;

  assign rise_lim  = {1'b0, cfg.rise_threshold};
  assign fall_lim  = {1'b0, cfg.fall_threshold};
  assign rep_lim   = {1'b0, cfg.repeat_threshold};
  assign rep_on    = (cfg.repeat_threshold != '0);
  assign count_inc = (tick_count == COUNT_MAX) ? tick_count : tick_count + 1'b1;

  always_comb begin
    phase_next = phase;
    count_next = tick_count;
    flag_step  = change_flag;
    case (phase)
      PH_STEADY_LOW: begin
        if (item.sample_level) begin
          phase_next = PH_RISING;
          count_next = '0;
        end else if (rep_on) begin
          if (count_inc > rep_lim) begin
            flag_step  = 1'b1;
            count_next = '0;
          end else begin
            count_next = count_inc;
          end
        end
      end
      PH_RISING: begin
        if (!item.sample_level) begin
          phase_next = PH_STEADY_LOW;
          count_next = '0;
        end else if (count_inc > rise_lim) begin
          phase_next = PH_STEADY_HIGH;
          flag_step  = 1'b1;
          count_next = '0;
        end else begin
          count_next = count_inc;
        end
      end
      PH_STEADY_HIGH: begin
        if (!item.sample_level) begin
          phase_next = PH_FALLING;
          count_next = '0;
        end else if (rep_on) begin
          if (count_inc > rep_lim) begin
            flag_step  = 1'b1;
            count_next = '0;
          end else begin
            count_next = count_inc;
          end
        end
      end
      PH_FALLING: begin
        if (item.sample_level) begin
          phase_next = PH_STEADY_HIGH;
          count_next = '0;
        end else if (count_inc > fall_lim) begin
          phase_next = PH_STEADY_LOW;
          flag_step  = 1'b1;
          count_next = '0;
        end else begin
          count_next = count_inc;
        end
      end
      default: begin
        phase_next = PH_STEADY_LOW;
        count_next = '0;
      end
    endcase
  end

  assign high_now = (phase_next == PH_STEADY_HIGH);

  assign result.debounced_level = high_now || (phase_next == PH_FALLING);
  assign result.change_pending  = flag_step;
  assign result.held_event      = high_now && flag_step;

  assign change_flag_next = flag_step && !item.ack_change && !(item.ack_repeat && high_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_STEADY_LOW;
      tick_count  <= '0;
      change_flag <= 1'b0;
    end else if (load) begin
      phase       <= phase_next;
      tick_count  <= count_next;
      change_flag <= change_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/button_debounce_with_repeat_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_with_repeat_unit
// Button debouncer with auto-repeat, one sample per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw button sample plus two acknowledge
// bits and yields exactly one result transaction: debounced level, change
// flag and held-repeat event. Throughput is one transaction per cycle while
// results are taken; an accepted sample reaches the output register in the
// following cycle, when the phase machine and tick counter update too. The
// output register lets a new sample in while a result waits, as long as that
// result is taken in the same cycle. Thresholds are written over the
// configuration channel, which is always ready; write only while idle.
// ----------------------------------------------------------------------------
module button_debounce_with_repeat_unit
  import bdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [THRESH_W-1:0]  cfg_data
);

  cfg_t cfg;
  out_t result;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  bdr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bdr_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .load   (in_fire),
    .item   (in_data),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted transaction produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_held_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.held_event |-> out_data.debounced_level && out_data.change_pending)
    else $error("held event without steady high level and pending change");
`endif

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the button debouncer with auto-repeat against a cycle-free predictor.
// A queue-fed driver offers samples with random gaps, a random-stall receiver
// takes reports, and a monitor predicts each report from the accepted sample
// and the thresholds written so far. Directed sequences cover glitches,
// repeat events, both acknowledges and a threshold lowered mid-count; random
// phases run debounce-length runs of each level under varied thresholds.
// ----------------------------------------------------------------------------
module testbench;
  import bdr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THRESH_W-1:0]  cfg_data = '0;

  in_t         pending_samples[$];
  out_t        expected_reports[$];
  int unsigned samples_queued = 0;
  int unsigned reports_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned reports_taken = 0;

  // predictor state
  phase_t               db_phase;
  logic [COUNT_W-1:0]   db_count;
  logic                 db_flag;
  logic [THRESH_W-1:0]  db_rise;
  logic [THRESH_W-1:0]  db_fall;
  logic [THRESH_W-1:0]  db_repeat;

  button_debounce_with_repeat_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void advance_count(input logic [THRESH_W-1:0] lim, input phase_t target);
    if (db_count != COUNT_MAX) db_count = db_count + 1'b1;
    if (db_count > {1'b0, lim}) begin
      db_phase = target;
      db_flag  = 1'b1;
      db_count = '0;
    end
  endfunction

  function automatic out_t debounce_step(input in_t smp);
    out_t rpt;
    logic high_now;
    if (smp.sample_level) begin
      case (db_phase)
        PH_STEADY_LOW: begin
          db_phase = PH_RISING;
          db_count = '0;
        end
        PH_RISING: advance_count(db_rise, PH_STEADY_HIGH);
        PH_STEADY_HIGH: if (db_repeat != 0) advance_count(db_repeat, PH_STEADY_HIGH);
        default: begin
          db_phase = PH_STEADY_HIGH;
          db_count = '0;
        end
      endcase
    end else begin
      case (db_phase)
        PH_STEADY_LOW: if (db_repeat != 0) advance_count(db_repeat, PH_STEADY_LOW);
        PH_RISING: begin
          db_phase = PH_STEADY_LOW;
          db_count = '0;
        end
        PH_STEADY_HIGH: begin
          db_phase = PH_FALLING;
          db_count = '0;
        end
        default: advance_count(db_fall, PH_STEADY_LOW);
      endcase
    end
    high_now = (db_phase == PH_STEADY_HIGH);
    rpt.debounced_level = high_now || (db_phase == PH_FALLING);
    rpt.change_pending  = db_flag;
    rpt.held_event      = high_now && db_flag;
    if (smp.ack_change) db_flag = 1'b0;
    if (smp.ack_repeat && high_now) db_flag = 1'b0;
    return rpt;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_data  <= pending_samples.pop_front();
        in_valid <= 1'b1;
        send_gap <= quiet ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // report receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready     <= 1'b0;
      stall_left    <= 0;
      reports_taken <= 0;
    end else begin
      if (out_valid && out_ready) reports_taken <= reports_taken + 1;
      if (out_valid && out_ready && (reports_taken % 700 == 350)) begin
        stall_left <= 250;
        out_ready  <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet) stall_left <= pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_reports
    out_t want;
    if (rst) begin
      db_phase  = PH_STEADY_LOW;
      db_count  = '0;
      db_flag   = 1'b0;
      db_rise   = '0;
      db_fall   = '0;
      db_repeat = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RISE:   db_rise = cfg_data;
          REG_FALL:   db_fall = cfg_data;
          REG_REPEAT: db_repeat = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        reports_seen <= reports_seen + 1;
        if (expected_reports.size() == 0) begin
          $error("unexpected report transaction %p", out_data);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (out_data.debounced_level !== want.debounced_level) begin
            $error("debounced_level: expected %b, got %b",
                   want.debounced_level, out_data.debounced_level);
            mismatches++;
          end
          if (out_data.change_pending !== want.change_pending) begin
            $error("change_pending: expected %b, got %b",
                   want.change_pending, out_data.change_pending);
            mismatches++;
          end
          if (out_data.held_event !== want.held_event) begin
            $error("held_event: expected %b, got %b",
                   want.held_event, out_data.held_event);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) expected_reports.push_back(debounce_step(in_data));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(input logic lvl, input logic ackc, input logic ackr);
    in_t smp;
    smp.sample_level = lvl;
    smp.ack_change   = ackc;
    smp.ack_repeat   = ackr;
    pending_samples.push_back(smp);
    samples_queued++;
  endtask

  task automatic send_random(input logic lvl);
    send(lvl, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    while (reports_seen < samples_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_thresholds(input logic [THRESH_W-1:0] rise,
                                  input logic [THRESH_W-1:0] fall,
                                  input logic [THRESH_W-1:0] rpt);
    write_reg(REG_UNUSED, THRESH_W'($urandom_range(0, 65535)));
    write_reg(REG_RISE, rise);
    write_reg(REG_FALL, fall);
    write_reg(REG_REPEAT, rpt);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [THRESH_W-1:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return THRESH_W'($urandom_range(0, 65535));
    if (r < 5) return '0;
    return THRESH_W'($urandom_range(1, 8));
  endfunction

  initial begin : stimulus
    logic                lvl;
    int unsigned         span;
    int unsigned         len;
    int unsigned         added;
    logic [THRESH_W-1:0] rise_v;
    logic [THRESH_W-1:0] fall_v;
    logic [THRESH_W-1:0] rep_v;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero thresholds: glitches, acknowledges, repeat off
    write_thresholds('0, '0, '0);
    send(1'b0, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b1);
    send(1'b1, 1'b0, 1'b0);
    send(1'b0, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b0, 1'b0, 1'b0);
    send(1'b0, 1'b0, 1'b1);
    send(1'b0, 1'b0, 1'b0);
    send(1'b1, 1'b1, 1'b1);
    send(1'b0, 1'b0, 1'b0);
    wait_drained();

    // repeat events while steady low and steady high
    write_thresholds(16'd1, 16'd1, 16'd1);
    send(1'b0, 1'b0, 1'b0);
    send(1'b0, 1'b1, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b1);
    send(1'b1, 1'b0, 1'b0);
    wait_drained();

    // maximum thresholds, then repeat threshold cleared mid-count
    write_thresholds('1, '1, '1);
    repeat (4) send(1'b0, 1'b0, 1'b0);
    wait_drained();
    write_thresholds('0, 16'd2, '0);
    send(1'b0, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    send(1'b1, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      rise_v = pick_threshold();
      fall_v = pick_threshold();
      rep_v  = pick_threshold();
      write_thresholds(rise_v, fall_v, rep_v);
      quiet <= (ph % 4 == 3);
      span = rise_v;
      if (fall_v > span) span = fall_v;
      if (rep_v > span) span = rep_v;
      span = (span > 36) ? 40 : span + 4;
      lvl = 1'($urandom_range(0, 1));
      added = 0;
      while (added < 130) begin
        if ($urandom_range(0, 9) < 7) begin
          lvl = ~lvl;
          len = $urandom_range(1, span);
          repeat (len) send_random(lvl);
        end else begin
          len = $urandom_range(1, 3);
          repeat (len) send_random(1'($urandom_range(0, 1)));
        end
        added += len;
      end
      wait_drained();
    end

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
